// ===== rtl/fpsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsm_pkg
// Shared types, register indexes and the case-folding helper for the
// fixed pattern stream matcher.
// ----------------------------------------------------------------------------
package fpsm_pkg;

  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int DATA_W    = 8;
  localparam int OFS_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_INSENSITIVE = 2'd2;

  localparam logic [DATA_W-1:0] CASE_BIT = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_LO  = 8'h61;
  localparam logic [DATA_W-1:0] CHAR_HI  = 8'h7a;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] len;      // already clamped to 1..MAX_PATTERN
    logic             ci;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic [OFS_W-1:0] offset;
  } match_t;

  function automatic logic [DATA_W-1:0] fold_byte(input logic [DATA_W-1:0] b,
                                                  input logic on);
    if (on && (b >= CHAR_LO) && (b <= CHAR_HI)) begin
      return b & ~CASE_BIT;
    end
    return b;
  endfunction

endpackage

// ===== rtl/fpsm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsm_cfg
// Configuration registers. The pattern length is clamped to 1..MAX_PATTERN
// when it is written.
// ----------------------------------------------------------------------------
module fpsm_cfg
  import fpsm_pkg::*;
#(
  parameter int MAX_PATTERN = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  logic [PAT_W-1:0] pattern_r;
  logic [LEN_W-1:0] len_r;
  logic             ci_r;
  logic [LEN_W-1:0] len_clamped;

  always_comb begin
    len_clamped = cfg_data[LEN_W-1:0];
    if (len_clamped == '0) begin
      len_clamped = LEN_W'(1);
    end else if (len_clamped > LEN_W'(MAX_PATTERN)) begin
      len_clamped = LEN_W'(MAX_PATTERN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      len_r     <= LEN_W'(1);
      ci_r      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BYTES:    pattern_r <= cfg_data;
        REG_PATTERN_LENGTH:   len_r     <= len_clamped;
        REG_CASE_INSENSITIVE: ci_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern = pattern_r;
  assign cfg.len     = len_r;
  assign cfg.ci      = ci_r;

endmodule

// ===== rtl/fpsm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsm_core
// Byte window, stream position and match counter, with the parallel compare
// of the newest bytes against the pattern for every possible length.
// ----------------------------------------------------------------------------
module fpsm_core
  import fpsm_pkg::*;
#(
  parameter int MAX_PATTERN = 8,
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              end_of_stream,
  input  cfg_t              cfg,
  output match_t            res
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic [DATA_W-1:0]      win_r   [MAX_PATTERN];
  logic [DATA_W-1:0]      win_sh  [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt, cnt_inc;
  logic [MAX_PATTERN:1]   hit_len;
  logic                   hit;
  logic [OFFSET_BITS-1:0] back;
  logic [OFFSET_BITS-1:0] first;
  logic [63:0]            first_ext;

  always_comb begin
    win_sh[0] = data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_sh[i] = win_r[i-1];
    end
  end

  // For a length L, pattern byte L-1-k lines up with window entry k.
  always_comb begin
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      hit_len[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (fold_byte(cfg.pattern[8*(l-1-k) +: 8], cfg.ci) !=
            fold_byte(win_sh[k], cfg.ci)) begin
          hit_len[l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cnt_inc = (cnt_r < CNT_W'(MAX_PATTERN)) ? cnt_r + CNT_W'(1) : cnt_r;
    hit     = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      if (cfg.len == LEN_W'(l)) begin
        hit = hit_len[l];
      end
    end
    if (LEN_W'(cnt_inc) < cfg.len) begin
      hit = 1'b0;
    end
    back      = OFFSET_BITS'(cfg.len) - OFFSET_BITS'(1);
    first     = (pos_r >= back) ? pos_r - back : '0;
    first_ext = 64'(first);
    cnt_nxt   = hit ? '0 : cnt_inc;
    pos_nxt   = (pos_r != '1) ? pos_r + OFFSET_BITS'(1) : pos_r;
  end

  assign res.hit    = hit;
  assign res.offset = first_ext[OFS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= '0;
      end
      pos_r <= '0;
      cnt_r <= '0;
    end else if (adv) begin
      if (end_of_stream) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win_r[i] <= '0;
        end
        pos_r <= '0;
        cnt_r <= '0;
      end else begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win_r[i] <= win_sh[i];
        end
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

// ===== rtl/fixed_pattern_stream_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_pattern_stream_matcher
// A match offset passes the input register (byte_r), then the result
// register (offset_r): the byte is captured at the accepting edge, the result
// when that byte advances. Throughput: one byte per cycle while out_stall
// leaves the result slot free; the whole window compare sits between them.
// Reset (synchronous, active low) clears the window, stream position and
// match count, and sets pattern 0, length 1, case-insensitive mode on.
// ----------------------------------------------------------------------------
module fixed_pattern_stream_matcher
  import fpsm_pkg::*;
#(
  parameter int MAX_PATTERN = 8,
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    in_data_byte,
  input  logic                 in_end_of_stream,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OFS_W-1:0]     out_match_offset,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data
);

  cfg_t              cfg;
  match_t            res;
  logic              in_v_r;
  logic [DATA_W-1:0] byte_r;
  logic              eos_r;
  logic              out_valid_r;
  logic [OFS_W-1:0]  offset_r;
  logic              out_free;
  logic              adv;
  logic              take;

  fpsm_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpsm_core #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .data_byte     (byte_r),
    .end_of_stream (eos_r),
    .cfg           (cfg),
    .res           (res)
  );

  // The result slot can be refilled when empty or when its word leaves now.
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = in_v_r && out_free;
  assign in_stall = in_v_r && !out_free;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (take) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_data_byte;
      eos_r  <= in_end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.hit) begin
      offset_r <= res.offset;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match_offset = offset_r;

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("input stalled with an empty input register");

  a_hit_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.hit |=> out_valid_r)
    else $error("match found but no result word presented");

  a_word_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv))
    else $error("result word appeared without an item in the compare stage");
`endif

endmodule
